// ===== src/sdq_pkg.sv =====
// Shared constants, codes and control types of the sorted double-ended queue.
package sdq_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RM_MIN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RM_MAX  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RM_NTH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RM_NTHL = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_ERR  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    RD_BELOW = 2'd0,
    RD_AT    = 2'd1,
    RD_ABOVE = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    cap_req;
    logic    check;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_val;
    logic    idx_dec;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cap_removed;
    logic    out_load;
  } sdq_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_ins;
    logic idx_zero;
    logic move_up;
    logic last;
    logic out_free;
  } sdq_sts_t;

endpackage

// ===== src/sdq_if.sv =====
// Request and result channel interfaces of the sorted double-ended queue.
interface sdq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [sdq_pkg::MODE_W-1:0]     mode;
  logic signed [sdq_pkg::DATA_W-1:0]     value;
  logic        [sdq_pkg::POS_W-1:0]      position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface sdq_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sdq_pkg::DATA_W-1:0]     removed_value;
  logic        [sdq_pkg::STAT_W-1:0]     status;
  logic        [sdq_pkg::OCC_W-1:0]      occupancy;

  modport source (output valid, removed_value, status, occupancy, input ready);
  modport sink   (input valid, removed_value, status, occupancy, output ready);
endinterface

// ===== src/sdq_ctrl.sv =====
// Controller state machine that sequences insert and removal steps.
module sdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdq_pkg::sdq_sts_t sts,
  output sdq_pkg::sdq_cmd_t cmd
);
  import sdq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_INS_RD = 9'b000000100,
    S_INS_WR = 9'b000001000,
    S_RM_RD  = 9'b000010000,
    S_RM_CAP = 9'b000100000,
    S_SH_RD  = 9'b001000000,
    S_SH_WR  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_AT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_req = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.bad) begin
          state_nxt = S_DONE;
        end else if (sts.is_ins) begin
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_INS_RD: begin
        if (sts.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BELOW;
          state_nxt  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en = 1'b1;
        if (sts.move_up) begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_INS_RD;
        end else begin
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_RM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT;
        state_nxt  = S_RM_CAP;
      end
      S_RM_CAP: begin
        cmd.cap_removed = 1'b1;
        state_nxt       = S_SH_RD;
      end
      S_SH_RD: begin
        if (sts.last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ABOVE;
          state_nxt  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_SH_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/sdq_datapath.sv =====
// Datapath: sorted value store, request and index registers, result register.
module sdq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sdq_pkg::sdq_cmd_t                   cmd,
  output sdq_pkg::sdq_sts_t                   sts,
  input  logic        [sdq_pkg::MODE_W-1:0]   in_mode,
  input  logic signed [sdq_pkg::DATA_W-1:0]   in_value,
  input  logic        [sdq_pkg::POS_W-1:0]    in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sdq_pkg::DATA_W-1:0]   out_removed_value,
  output logic        [sdq_pkg::STAT_W-1:0]   out_status,
  output logic        [sdq_pkg::OCC_W-1:0]    out_occupancy
);
  import sdq_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  logic        [MODE_W-1:0] mode_r;
  logic signed [DATA_W-1:0] val_r;
  logic        [POS_W-1:0]  pos_r;
  logic        [CNT_W-1:0]  count_r;
  logic        [IDX_W-1:0]  idx_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic signed [DATA_W-1:0] removed_r;
  logic        [STAT_W-1:0] st_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_removed_r;
  logic        [STAT_W-1:0] out_status_r;
  logic        [OCC_W-1:0]  out_occ_r;

  logic        [STAT_W-1:0] st_eval;
  logic        [CMP_W-1:0]  cnt_x;
  logic        [CMP_W-1:0]  pos_x;
  logic        [CMP_W-1:0]  slot_x;
  logic        [IDX_W-1:0]  rd_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic        [CNT_W-1:0]  idx_next;

  assign cnt_x    = CMP_W'(count_r);
  assign pos_x    = CMP_W'(pos_r);
  assign idx_next = CNT_W'(idx_r) + CNT_W'(1);

  always_comb begin
    st_eval = ST_DONE;
    slot_x  = '0;
    case (mode_r)
      MODE_INSERT: begin
        if (cnt_x >= CMP_W'(CAPACITY)) st_eval = ST_FULL;
        slot_x = cnt_x;
      end
      MODE_RM_MIN: begin
        if (count_r == '0) st_eval = ST_ERR;
        slot_x = '0;
      end
      MODE_RM_MAX: begin
        if (count_r == '0) st_eval = ST_ERR;
        slot_x = cnt_x - CMP_W'(1);
      end
      MODE_RM_NTH: begin
        if (pos_r == '0 || pos_x > cnt_x) st_eval = ST_ERR;
        slot_x = pos_x - CMP_W'(1);
      end
      MODE_RM_NTHL: begin
        if (pos_r == '0 || pos_x > cnt_x) st_eval = ST_ERR;
        slot_x = cnt_x - pos_x;
      end
      default: begin
        st_eval = ST_ERR;
      end
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_BELOW: rd_addr = idx_r - IDX_W'(1);
      RD_AT:    rd_addr = idx_r;
      RD_ABOVE: rd_addr = idx_r + IDX_W'(1);
      default:  rd_addr = idx_r;
    endcase
  end

  assign wr_data = cmd.wr_val ? val_r : rd_data_r;

  assign sts.bad      = (st_eval != ST_DONE);
  assign sts.is_ins   = (mode_r == MODE_INSERT);
  assign sts.idx_zero = (idx_r == '0);
  assign sts.move_up  = (rd_data_r >= val_r);
  assign sts.last     = (idx_next >= count_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.wr_en) begin
      mem[idx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      mode_r <= in_mode;
      val_r  <= in_value;
      pos_r  <= in_position;
    end
    if (cmd.check) begin
      st_r      <= st_eval;
      removed_r <= '0;
      idx_r     <= slot_x[IDX_W-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - IDX_W'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.cap_removed) begin
      removed_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_removed_r <= removed_r;
      out_status_r  <= st_r;
      out_occ_r     <= OCC_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  assign out_occupancy     = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1) || count_r == $past(count_r) - CNT_W'(1)))
    else $error("stored count moved by more than one");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && st_r == ST_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status while store has room");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && st_r != ST_DONE) |-> (removed_r == '0))
    else $error("failed request returns a value");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.check && sts.bad) |=> (count_r == $past(count_r)))
    else $error("rejected request changed the count");

endmodule

// ===== src/sorted_double_ended_queue.sv =====
// Top level of the sorted double-ended queue: controller plus datapath.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------
//   in_req   | sink      | mode, value, position
//   out_res  | source    | removed_value, status, occupancy
//
// A request is accepted and checked; an insert moves entries >= the value up by read/write pairs,
// a removal captures its entry and shifts the entries above it down, then the result is loaded.
// The single write/read port of the value store moves one entry per read and write pair.
// Reset clears the count and the result valid flag; the value store needs no clearing.
// A new word is accepted while the previous result waits; a stalled result holds the
// next request at its last step.
module sorted_double_ended_queue (
  input  logic clk,
  input  logic rst_n,
  sdq_req_if.sink   in_req,
  sdq_res_if.source out_res
);
  import sdq_pkg::*;

  sdq_cmd_t cmd;
  sdq_sts_t sts;
  logic     in_ready;

  assign in_req.ready = in_ready;

  sdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdq_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_req.mode),
    .in_value          (in_req.value),
    .in_position       (in_req.position),
    .out_valid         (out_res.valid),
    .out_ready         (out_res.ready),
    .out_removed_value (out_res.removed_value),
    .out_status        (out_res.status),
    .out_occupancy     (out_res.occupancy)
  );

endmodule

// ===== verif/sdq_checker.sv =====
// Result checker for the sorted double-ended queue: shadow store, expected-result queue, compare.
`timescale 1ns / 100ps

module sdq_checker (
  input  logic clk,
  input  logic rst_n,
  sdq_req_if   req,
  sdq_res_if   res,
  output int   fail_count,
  output int   pending
);
  import sdq_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic        [STAT_W-1:0] status;
    logic        [OCC_W-1:0]  occupancy;
  } sdq_result_t;

  logic signed [DATA_W-1:0] held_values [CAPACITY];
  int                       held_count;
  sdq_result_t              expected_results [$];

  function automatic logic signed [DATA_W-1:0] take_slot(input int slot);
    logic signed [DATA_W-1:0] taken;
    int                       i;
    taken = held_values[slot];
    for (i = slot; i + 1 < held_count; i++) held_values[i] = held_values[i + 1];
    held_count--;
    return taken;
  endfunction

  function automatic sdq_result_t serve_request(input logic [MODE_W-1:0] mode,
                                                input logic signed [DATA_W-1:0] value,
                                                input logic [POS_W-1:0] position);
    sdq_result_t outcome;
    int          slot;
    int          i;
    outcome = '0;
    outcome.status = ST_DONE;
    case (mode)
      MODE_INSERT: begin
        if (held_count >= CAPACITY) begin
          outcome.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < held_count && held_values[slot] < value) slot++;
          for (i = held_count; i > slot; i--) held_values[i] = held_values[i - 1];
          held_values[slot] = value;
          held_count++;
        end
      end
      MODE_RM_MIN, MODE_RM_MAX: begin
        if (held_count == 0) outcome.status = ST_ERR;
        else outcome.removed_value = take_slot(mode == MODE_RM_MIN ? 0 : held_count - 1);
      end
      MODE_RM_NTH, MODE_RM_NTHL: begin
        if (position == 0 || position > held_count) outcome.status = ST_ERR;
        else outcome.removed_value = take_slot(mode == MODE_RM_NTH ? int'(position) - 1
                                                                  : held_count - int'(position));
      end
      default: begin
        outcome.status = ST_ERR;
      end
    endcase
    outcome.occupancy = OCC_W'(held_count);
    return outcome;
  endfunction

  function automatic void compare_field(input string field, input longint want,
                                        input longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : track
    sdq_result_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, actual value %0d status %0d occ %0d",
                   $time, res.removed_value, res.status, res.occupancy);
        end else begin
          want = expected_results.pop_front();
          compare_field("removed_value", want.removed_value, res.removed_value);
          compare_field("status", want.status, res.status);
          compare_field("occupancy", want.occupancy, res.occupancy);
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(serve_request(req.mode, req.value, req.position));
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/tb_sorted_double_ended_queue.sv =====
// Testbench top for the sorted double-ended queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_double_ended_queue;
  import sdq_pkg::*;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic [MODE_W-1:0]        MODE_SPARE = MODE_RM_NTHL + 3'd1;
  localparam int                       HOLD_CYCLES = 300;
  localparam int                       PHASE_WORDS = 650;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_idle;
  bit   hold_req;
  bit   hold_done;
  int   fails;
  int   pending;
  int   stock;
  int   words_sent;

  sdq_req_if in_req ();
  sdq_res_if out_res ();

  sorted_double_ended_queue DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  sdq_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .res        (out_res),
    .fail_count (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("tb_sorted_double_ended_queue: done, errors");
    $finish;
  end

  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_res.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] mode,
                           input logic signed [DATA_W-1:0] value,
                           input logic [POS_W-1:0] position);
    if ($urandom_range(99) < send_idle) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.mode     <= mode;
    in_req.value    <= value;
    in_req.position <= position;
    do @(posedge clk); while (!in_req.ready);
    words_sent++;
    case (mode)
      MODE_INSERT:               if (stock < CAPACITY) stock++;
      MODE_RM_MIN, MODE_RM_MAX:  if (stock > 0) stock--;
      MODE_RM_NTH, MODE_RM_NTHL: if (position != 0 && position <= stock) stock--;
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input bit narrow);
    case ($urandom_range(9))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2, 3:    return $signed($urandom_range(16)) - 8;
      default: return narrow ? $signed($urandom_range(6)) - 3 : $signed($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_rank(input bit strict);
    int r;
    r = strict ? 9 : $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return POS_W'($urandom_range(63, stock + 1));
    if (r == 2) return POS_W'($urandom_range(63));
    if (stock == 0) return POS_W'($urandom_range(3, 1));
    return POS_W'($urandom_range(stock, 1));
  endfunction

  initial begin
    int               phase;
    int               target;
    int               n;
    int               r;
    bit               narrow;
    logic [MODE_W-1:0] op;
    rst_n           = 1'b0;
    in_req.valid    = 1'b0;
    in_req.mode     = MODE_INSERT;
    in_req.value    = '0;
    in_req.position = '0;
    send_idle       = 0;
    recv_idle       = 0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    stock           = 0;
    words_sent      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 38;
    recv_idle = 49;
    send_word(MODE_RM_MIN, 0, 0);
    send_word(MODE_RM_MAX, -1, 6'h3F);
    send_word(MODE_RM_NTH, 0, 1);
    send_word(MODE_RM_NTHL, 0, 0);
    send_word(MODE_SPARE, INT_MAX, 6'h3F);
    send_word(MODE_SPARE + 3'd1, INT_MIN, 1);
    send_word(MODE_SPARE + 3'd2, -1, 2);
    send_word(MODE_INSERT, INT_MAX, 0);
    send_word(MODE_INSERT, INT_MIN, 0);
    send_word(MODE_INSERT, 0, 0);
    send_word(MODE_INSERT, -1, 0);
    send_word(MODE_INSERT, 0, 0);
    send_word(MODE_INSERT, 1, 0);
    send_word(MODE_RM_NTH, 0, 0);
    send_word(MODE_RM_NTHL, 0, 7);
    send_word(MODE_RM_NTH, 0, 2);
    send_word(MODE_RM_NTHL, 0, 2);
    send_word(MODE_RM_MIN, 0, 0);
    send_word(MODE_RM_MAX, 0, 0);
    send_word(MODE_RM_NTHL, 0, 2);
    send_word(MODE_RM_NTH, 0, 1);
    send_word(MODE_RM_NTH, 0, 6'h3F);

    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 38 : (phase == 1) ? 49 : 0;
      recv_idle = (phase == 0) ? 49 : (phase == 1) ? 38 : 0;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        if (phase == 0 && !hold_done && words_sent > 120) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        r      = $urandom_range(9);
        narrow = ($urandom_range(3) == 0);
        if (r < 3) begin
          while (stock < CAPACITY) send_word(MODE_INSERT, pick_value(narrow), pick_rank(0));
          repeat ($urandom_range(2, 1)) send_word(MODE_INSERT, pick_value(narrow), 0);
        end else if (r < 6) begin
          while (stock > 0) begin
            op = MODE_W'($urandom_range(MODE_RM_NTHL, MODE_RM_MIN));
            send_word(op, pick_value(0), pick_rank(1));
          end
          send_word(MODE_W'($urandom_range(MODE_RM_NTHL, MODE_RM_MIN)), 0, pick_rank(0));
        end else begin
          n = $urandom_range(24, 8);
          repeat (n) begin
            r = $urandom_range(99);
            if (r < 40)      op = MODE_INSERT;
            else if (r < 52) op = MODE_RM_MIN;
            else if (r < 64) op = MODE_RM_MAX;
            else if (r < 78) op = MODE_RM_NTH;
            else if (r < 92) op = MODE_RM_NTHL;
            else             op = MODE_W'($urandom_range(7, MODE_SPARE));
            send_word(op, pick_value(narrow), pick_rank(0));
          end
        end
      end
    end
    in_req.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_sorted_double_ended_queue: done, clean");
    end else begin
      $display("tb_sorted_double_ended_queue: done, errors");
    end
    $finish;
  end

endmodule

// ===== sorted_double_ended_queue.f =====
src/sdq_pkg.sv
src/sdq_if.sv
src/sdq_ctrl.sv
src/sdq_datapath.sv
src/sorted_double_ended_queue.sv
verif/sdq_checker.sv
verif/tb_sorted_double_ended_queue.sv
